[hdl/mqd_pkg.sv]
// ----------------------------------------------------------------------------
// mqd_pkg
// Shared types and constants for the MQTT packet deframer: parse phases,
// byte roles and the per-byte result record.
// ----------------------------------------------------------------------------
package mqd_pkg;

  localparam int LEN_W  = 28;
  localparam int TLEN_W = 16;
  localparam int CNT_W  = 3;

  localparam logic [LEN_W-1:0] LEN_MAX      = {LEN_W{1'b1}};
  localparam logic [3:0]       TYPE_PUBLISH = 4'd3;
  localparam logic [3:0]       QOS_MASK     = 4'h6;
  localparam logic [CNT_W-1:0] LEN_BYTES_MAX = 3'd4;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_IDENT   = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_BODY    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_TYPE    = 3'd0,
    ROLE_LEN     = 3'd1,
    ROLE_TLEN    = 3'd2,
    ROLE_TOPIC   = 3'd3,
    ROLE_IDENT   = 3'd4,
    ROLE_PAYLOAD = 3'd5,
    ROLE_BODY    = 3'd6
  } role_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] ptype;
    logic [3:0] flags;
    role_t      role;
    logic       last;
    logic       bad;
  } result_t;

endpackage

[hdl/mqd_parser.sv]
// ----------------------------------------------------------------------------
// mqd_parser
// Framing state of the deframer. Classifies the byte on its input and
// advances the parse state when the beat is accepted.
// ----------------------------------------------------------------------------
module mqd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                byte_in,
  input  logic [mqd_pkg::LEN_W-1:0] max_len,
  output mqd_pkg::result_t          result
);
  import mqd_pkg::*;

  phase_t              phase, phase_next;
  logic [3:0]          cur_type, cur_type_next;
  logic [3:0]          cur_flags, cur_flags_next;
  logic [LEN_W-1:0]    bytes_left, bytes_left_next;
  logic [CNT_W-1:0]    len_count, len_count_next;
  logic [TLEN_W-1:0]   topic_left, topic_left_next;
  logic [1:0]          ident_left, ident_left_next;

  logic [4:0]          shamt;
  logic [LEN_W-1:0]    len_acc;
  logic [LEN_W-1:0]    body_left;
  logic [TLEN_W-1:0]   topic_dec;
  logic [TLEN_W-1:0]   topic_full;
  logic [1:0]          ident_dec;
  logic                has_ident;

  // Hold parse state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      cur_type   <= '0;
      cur_flags  <= '0;
      bytes_left <= '0;
      len_count  <= '0;
      topic_left <= '0;
      ident_left <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      cur_type   <= cur_type_next;
      cur_flags  <= cur_flags_next;
      bytes_left <= bytes_left_next;
      len_count  <= len_count_next;
      topic_left <= topic_left_next;
      ident_left <= ident_left_next;
    end
  end

  // Seven-bit group position of the current length byte
  always_comb begin
    unique case (len_count[1:0])
      2'd0:    shamt = 5'd0;
      2'd1:    shamt = 5'd7;
      2'd2:    shamt = 5'd14;
      default: shamt = 5'd21;
    endcase
  end

  assign len_acc    = bytes_left | (LEN_W'(byte_in[6:0]) << shamt);
  assign body_left  = bytes_left - LEN_W'(1);
  assign topic_dec  = topic_left - TLEN_W'(1);
  assign topic_full = {topic_left[TLEN_W-1:8], byte_in};
  assign ident_dec  = ident_left - 2'd1;
  assign has_ident  = (cur_flags & QOS_MASK) != 4'h0;

  // Classify the byte and compute the next parse state
  always_comb begin
    phase_next      = phase;
    cur_type_next   = cur_type;
    cur_flags_next  = cur_flags;
    bytes_left_next = bytes_left;
    len_count_next  = len_count;
    topic_left_next = topic_left;
    ident_left_next = ident_left;
    result.data     = byte_in;
    result.role     = ROLE_BODY;
    result.last     = 1'b0;
    result.bad      = 1'b0;

    unique case (phase)
      PH_TYPE: begin
        cur_type_next   = byte_in[7:4];
        cur_flags_next  = byte_in[3:0];
        bytes_left_next = '0;
        len_count_next  = '0;
        topic_left_next = '0;
        ident_left_next = '0;
        result.role     = ROLE_TYPE;
        phase_next      = PH_LEN;
      end
      PH_LEN: begin
        result.role     = ROLE_LEN;
        bytes_left_next = len_acc;
        len_count_next  = len_count + CNT_W'(1);
        priority if (byte_in[7]) begin
          if (len_count_next >= LEN_BYTES_MAX) begin
            result.bad      = 1'b1;
            result.last     = 1'b1;
            bytes_left_next = '0;
            phase_next      = PH_TYPE;
          end
        end else if (len_acc > max_len) begin
          result.bad      = 1'b1;
          result.last     = 1'b1;
          bytes_left_next = '0;
          phase_next      = PH_TYPE;
        end else if (len_acc == '0) begin
          result.last = 1'b1;
          phase_next  = PH_TYPE;
        end else begin
          phase_next = (cur_type == TYPE_PUBLISH) ? PH_TLEN_HI : PH_BODY;
        end
      end
      PH_TLEN_HI: begin
        result.role     = ROLE_TLEN;
        topic_left_next = {byte_in, 8'h00};
        phase_next      = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        result.role     = ROLE_TLEN;
        topic_left_next = topic_full;
        priority if (topic_full != '0) begin
          phase_next = PH_TOPIC;
        end else if (has_ident) begin
          ident_left_next = 2'd2;
          phase_next      = PH_IDENT;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_TOPIC: begin
        result.role     = ROLE_TOPIC;
        topic_left_next = topic_dec;
        if (topic_dec == '0) begin
          if (has_ident) begin
            ident_left_next = 2'd2;
            phase_next      = PH_IDENT;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_IDENT: begin
        result.role     = ROLE_IDENT;
        ident_left_next = ident_dec;
        if (ident_dec == 2'd0) begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result.role = ROLE_PAYLOAD;
      end
      PH_BODY: begin
        result.role = ROLE_BODY;
      end
      default: begin
        result.role = ROLE_BODY;
      end
    endcase

    // Count down the body and close the packet on its final byte
    if (phase != PH_TYPE && phase != PH_LEN) begin
      bytes_left_next = body_left;
      if (body_left == '0) begin
        result.last = 1'b1;
        phase_next  = PH_TYPE;
      end
    end

    result.ptype = cur_type_next;
    result.flags = cur_flags_next;
  end

endmodule

[hdl/mqtt_packet_deframer.sv]
// ----------------------------------------------------------------------------
// mqtt_packet_deframer
// Tags each byte of a stream of MQTT control packets with packet type,
// header flags, byte role, end of packet and length fault.
// ----------------------------------------------------------------------------
// Output: each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; the output register takes a new result in
// the same cycle as the previous one leaves.
// Reset: parser expects a type byte, all counters are cleared and the
// length limit returns to its largest value.
module mqtt_packet_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [mqd_pkg::LEN_W-1:0] max_remaining_length,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                byte_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                byte_out,
  output logic [3:0]                packet_type,
  output logic [3:0]                header_flags,
  output logic [2:0]                byte_role,
  output logic                      last_of_packet,
  output logic                      malformed
);
  import mqd_pkg::*;

  logic [LEN_W-1:0] max_len;
  logic             accept;
  result_t          result;
  result_t          out_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // Hold the length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_MAX;
    end else if (cfg_valid) begin
      max_len <= max_remaining_length;
    end
  end

  mqd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .byte_in (byte_in),
    .max_len (max_len),
    .result  (result)
  );

  // Output register: load on accept, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= result;
    end
  end

  assign byte_out       = out_res.data;
  assign packet_type    = out_res.ptype;
  assign header_flags   = out_res.flags;
  assign byte_role      = 3'(out_res.role);
  assign last_of_packet = out_res.last;
  assign malformed      = out_res.bad;

endmodule

[sim/tb_mqtt_packet_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mqtt_packet_deframer
// Self-checking bench for the MQTT packet deframer. Byte beats are fed
// through the input handshake. A predictor tracks the parse state and tags
// each accepted byte. Every output beat is compared field by field against
// the oldest pending tag. Stimulus: a directed set of edge cases, then
// mostly well-formed packets with random content, mixed with broken
// lengths and raw noise. This runs under several length limits and
// several idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_mqtt_packet_deframer;
  import mqd_pkg::*;

  // Track parse state and hold the tags still owed by the block
  class tag_predictor;
    phase_t           phase;
    logic [3:0]       ptype;
    logic [3:0]       flags;
    logic [LEN_W-1:0] remaining;
    logic [CNT_W-1:0] len_cnt;
    logic [15:0]      topic_left;
    logic [1:0]       ident_left;
    logic [LEN_W-1:0] limit;
    result_t          expected_tags[$];
    int               mismatches;
    int               checked;
    int               flagged;

    function new();
      phase      = PH_TYPE;
      ptype      = '0;
      flags      = '0;
      remaining  = '0;
      len_cnt    = '0;
      topic_left = '0;
      ident_left = '0;
      limit      = LEN_MAX;
      mismatches = 0;
      checked    = 0;
      flagged    = 0;
    endfunction

    function void set_limit(logic [LEN_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction

    // Identifier comes next when QoS is nonzero (QoS three included)
    function phase_t qos_next();
      if ((flags & QOS_MASK) != 4'h0) begin
        ident_left = 2'd2;
        return PH_IDENT;
      end
      return PH_PAYLOAD;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      phase_t  nxt;
      r = '{data: b, ptype: 4'h0, flags: 4'h0, role: ROLE_BODY, last: 1'b0, bad: 1'b0};
      nxt = phase;
      case (phase)
        PH_TYPE: begin
          ptype      = b[7:4];
          flags      = b[3:0];
          remaining  = '0;
          len_cnt    = '0;
          topic_left = '0;
          ident_left = '0;
          r.role     = ROLE_TYPE;
          nxt        = PH_LEN;
        end
        PH_LEN: begin
          // Seven bits per length byte, low group first
          r.role    = ROLE_LEN;
          remaining = remaining | (LEN_W'(b[6:0]) << (7 * len_cnt[1:0]));
          len_cnt   = len_cnt + 3'd1;
          if (b[7]) begin
            if (len_cnt >= LEN_BYTES_MAX) begin
              r.bad = 1'b1; r.last = 1'b1; remaining = '0; nxt = PH_TYPE;
            end
          end else if (remaining > limit) begin
            r.bad = 1'b1; r.last = 1'b1; remaining = '0; nxt = PH_TYPE;
          end else if (remaining == '0) begin
            r.last = 1'b1; nxt = PH_TYPE;
          end else begin
            nxt = (ptype == TYPE_PUBLISH) ? PH_TLEN_HI : PH_BODY;
          end
        end
        default: begin
          case (phase)
            PH_TLEN_HI: begin
              r.role     = ROLE_TLEN;
              topic_left = {b, 8'h00};
              nxt        = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
              r.role     = ROLE_TLEN;
              topic_left = topic_left | {8'h00, b};
              nxt        = (topic_left != 16'h0) ? PH_TOPIC : qos_next();
            end
            PH_TOPIC: begin
              r.role     = ROLE_TOPIC;
              topic_left = topic_left - 16'd1;
              if (topic_left == 16'h0) nxt = qos_next();
            end
            PH_IDENT: begin
              r.role     = ROLE_IDENT;
              ident_left = ident_left - 2'd1;
              if (ident_left == 2'd0) nxt = PH_PAYLOAD;
            end
            PH_PAYLOAD: r.role = ROLE_PAYLOAD;
            default:    r.role = ROLE_BODY;
          endcase
          // Body count runs out: packet ends here, wherever the parse stands
          remaining = remaining - 1'b1;
          if (remaining == '0) begin
            r.last = 1'b1; nxt = PH_TYPE;
          end
        end
      endcase
      r.ptype = ptype;
      r.flags = flags;
      phase   = nxt;
      expected_tags.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
      end
    endfunction

    function void check_tag(result_t got);
      result_t want;
      if (expected_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: unexpected beat, expected none, actual byte %0h", $time, got.data);
        return;
      end
      want = expected_tags.pop_front();
      checked++;
      if (want.bad) flagged++;
      compare("byte_out", 32'(want.data), 32'(got.data));
      compare("packet_type", 32'(want.ptype), 32'(got.ptype));
      compare("header_flags", 32'(want.flags), 32'(got.flags));
      compare("byte_role", 32'(want.role), 32'(got.role));
      compare("last_of_packet", 32'(want.last), 32'(got.last));
      compare("malformed", 32'(want.bad), 32'(got.bad));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] max_remaining_length = LEN_MAX;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       byte_in = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       byte_out;
  logic [3:0]       packet_type;
  logic [3:0]       header_flags;
  logic [2:0]       byte_role;
  logic             last_of_packet;
  logic             malformed;

  tag_predictor     pred = new();
  result_t          seen;
  logic [LEN_W-1:0] cur_limit = LEN_MAX;
  int               send_idle = 0;
  int               recv_idle = 0;
  int               hold_req = 0;
  int               hold_left = 0;
  int               n_bytes = 0;
  int               n_packets = 0;

  mqtt_packet_deframer i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .max_remaining_length (max_remaining_length),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .byte_in              (byte_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .byte_out             (byte_out),
    .packet_type          (packet_type),
    .header_flags         (header_flags),
    .byte_role            (byte_role),
    .last_of_packet       (last_of_packet),
    .malformed            (malformed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: long hold-offs on request, otherwise random backpressure
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Check every output beat against the oldest pending tag
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.data  = byte_out;
      seen.ptype = packet_type;
      seen.flags = header_flags;
      seen.role  = role_t'(byte_role);
      seen.last  = last_of_packet;
      seen.bad   = malformed;
      pred.check_tag(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    pred.note_byte(b);
    n_bytes++;
  endtask

  // Drop valid and wait until every tag has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pred.pending() != 0);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_valid            <= 1'b1;
    max_remaining_length <= v;
    do @(posedge clk); while (!cfg_ready);
    pred.set_limit(v);
    cur_limit = v;
    cfg_valid <= 1'b0;
  endtask

  // Keep noise lengths short: cap the second group, zero the later ones
  function automatic logic [7:0] tame_length(input logic [7:0] b);
    if (pred.phase == PH_LEN && pred.len_cnt == 3'd1) return b & 8'h83;
    if (pred.phase == PH_LEN && pred.len_cnt >= 3'd2) return b & 8'h80;
    return b;
  endfunction

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(tame_length(8'($urandom)));
    // finish whatever packet the noise left open
    while (pred.phase != PH_TYPE) send_byte(tame_length(8'($urandom)));
  endtask

  task automatic send_packet();
    logic [7:0]  body[$];
    logic [7:0]  lenb[$];
    logic [3:0]  ptype;
    logic [3:0]  flags;
    int unsigned tl;
    int unsigned plen;
    int unsigned v;
    int          idx;
    bit          broken;
    ptype  = ($urandom_range(1) != 0) ? TYPE_PUBLISH : 4'($urandom_range(15));
    flags  = 4'($urandom);
    broken = ($urandom_range(7) == 0);
    // Build a publish body: topic length, topic, identifier when QoS set
    if (ptype == TYPE_PUBLISH) begin
      tl = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      body.push_back(8'(tl >> 8));
      body.push_back(8'(tl));
      repeat (tl) body.push_back(8'($urandom));
      if ((flags & QOS_MASK) != 4'h0) repeat (2) body.push_back(8'($urandom));
      if (broken) begin
        body[0] = 8'($urandom);
        body[1] = 8'($urandom);
      end
    end
    plen = ($urandom_range(15) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
    repeat (plen) body.push_back(8'($urandom));
    v = broken ? $urandom_range(0, body.size() + 4) : body.size();
    if ($urandom_range(15) == 0 && cur_limit < LEN_MAX)
      v = $urandom_range(int'(cur_limit) + 1, int'(LEN_MAX));
    // Encode the remaining length, now and then padded or overlong
    do begin
      lenb.push_back(8'(v % 128) | ((v >= 128) ? 8'h80 : 8'h00));
      v = v / 128;
    end while (v != 0);
    if ($urandom_range(7) == 0)
      while (lenb.size() < 4 && $urandom_range(1) != 0) begin
        lenb[lenb.size()-1] = lenb[lenb.size()-1] | 8'h80;
        lenb.push_back(8'h00);
      end
    if ($urandom_range(19) == 0) begin
      lenb.delete();
      repeat (4) lenb.push_back(8'h80 | 8'($urandom));
    end
    send_byte({ptype, flags});
    foreach (lenb[i]) send_byte(lenb[i]);
    idx = 0;
    while (pred.phase != PH_TYPE) begin
      send_byte((idx < body.size()) ? body[idx] : 8'($urandom));
      idx++;
    end
    n_packets++;
  endtask

  task automatic run_random(input int n);
    int stop;
    stop = n_bytes + n;
    while (n_bytes < stop) begin
      if ($urandom_range(11) == 0) send_noise();
      else send_packet();
    end
  endtask

  initial begin
    // empty body, type 0; overlong length, type 15; publish QoS1 with
    // every role; other body on a subscribe
    logic [7:0] seq_full [19] = '{8'h00, 8'h00,
                                  8'hF0, 8'h80, 8'h80, 8'h80, 8'h80,
                                  8'h3B, 8'h07, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34,
                                  8'hFF, 8'h00,
                                  8'h82, 8'h01, 8'h5A};
    // over limit; QoS three with topic running past the body
    logic [7:0] seq_tight [7] = '{8'h20, 8'h06,
                                  8'h36, 8'h03, 8'h00, 8'h05, 8'h78};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (seq_full[i]) send_byte(seq_full[i]);
    drain();
    write_limit(LEN_W'(5));
    foreach (seq_tight[i]) send_byte(seq_tight[i]);
    drain();

    // Sender mostly busy, receiver mostly stalled
    send_idle = 24;
    recv_idle = 62;
    write_limit(LEN_MAX);
    run_random(650);

    // Hold the receiver off and keep pushing so the input stalls
    hold_req  = 150;
    send_idle = 0;
    run_random(60);
    drain();

    // Swap the idle pattern; empty bodies only, then a small limit
    send_idle = 62;
    recv_idle = 24;
    write_limit('0);
    run_random(150);
    drain();
    write_limit(LEN_W'($urandom_range(1, 300)));
    run_random(500);
    drain();

    // No idling at all
    send_idle = 0;
    recv_idle = 0;
    write_limit(LEN_W'($urandom_range(301, int'(LEN_MAX))));
    run_random(350);
    drain();
    write_limit(LEN_MAX);
    run_random(200);
    drain();

    repeat (8) @(posedge clk);
    $display("Checked %0d tagged bytes in about %0d packets, %0d flagged malformed.",
             pred.checked, n_packets, pred.flagged);
    $display("Limits from zero to full range, stalls and gaps on both sides of the handshake.");
    if (pred.mismatches == 0 && pred.pending() == 0) begin
      $display("** mqtt_packet_deframer: PASSED **");
    end else begin
      $display("** mqtt_packet_deframer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Timeout with %0d tags still pending.", pred.pending());
    $display("** mqtt_packet_deframer: FAILED **");
    $finish;
  end

endmodule
